### rtl/rac_pkg.sv
package rac_pkg;

    // default delay line length, in samples
    localparam int WINDOW_LEN_DEF = 256;

    // field widths
    localparam int DATA_W    = 16;
    localparam int ROOT_W    = 15;
    localparam int CFG_IDX_W = 3;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // gain is q5.27
    localparam int GAIN_FRAC = 27;
    localparam logic signed [MUL_B_W-1:0] GAIN_ONE = MUL_B_W'(1) <<< GAIN_FRAC;
    localparam logic signed [MUL_P_W-1:0] OUT_ROUND = MUL_P_W'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [MUL_P_W-1:0] SAMPLE_MAX = MUL_P_W'(32767);
    localparam logic signed [MUL_P_W-1:0] SAMPLE_MIN = -MUL_P_W'(32768);

    // envelope update rounding and ceiling
    localparam logic [MUL_P_W-1:0] ENV_ROUND = MUL_P_W'(32768);
    localparam logic [DATA_W-1:0]  ENV_MAX   = 16'h7fff;

    // register reset values
    localparam logic [DATA_W-1:0] THRESHOLD_RST = 16'd32768;
    localparam logic [DATA_W-1:0] SLOPE_RST     = 16'd0;
    localparam logic [DATA_W-1:0] ATTACK_RST    = 16'd24109;
    localparam logic [DATA_W-1:0] RELEASE_RST   = 16'd24109;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_SLOPE     = 3'd1,
        CFG_ATTACK    = 3'd2,
        CFG_RELEASE   = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

    // bits of the running sum of squares: holds window_len * 2^30
    function automatic int sum_width(input int window_len);
        return $clog2(window_len + 1) + 30;
    endfunction

endpackage

### rtl/rac_ram.sv
module rac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rac_mul.sv
module rac_mul (
    input  logic                                clk,
    input  logic signed [rac_pkg::MUL_A_W-1:0]  a,
    input  logic signed [rac_pkg::MUL_B_W-1:0]  b,
    output logic signed [rac_pkg::MUL_P_W-1:0]  p
);

    logic signed [rac_pkg::MUL_P_W-1:0] p_reg;

    // signed product, registered
    always_ff @(posedge clk)
    begin
        p_reg <= rac_pkg::MUL_P_W'(a) * rac_pkg::MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

### rtl/rac_root.sv
module rac_root #(
    parameter int WINDOW_LEN = rac_pkg::WINDOW_LEN_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [rac_pkg::sum_width(WINDOW_LEN)-1:0]     value,
    output logic [rac_pkg::ROOT_W-1:0]                    root,
    output rac_pkg::root_stat_t                           stat
);

    localparam int SUM_W = rac_pkg::sum_width(WINDOW_LEN);
    localparam int TW    = SUM_W + 2;
    localparam int RW    = rac_pkg::ROOT_W;
    // (window_len + 1) * 2^(2k) for the top digit
    localparam logic [TW-1:0] C2_INIT = TW'(WINDOW_LEN + 1) << (2 * (RW - 1));

    // finds largest r with (window_len + 1) * r^2 <= value, one bit a cycle
    // q = d * r^2, p = d * r * 2^(k+1), c2 = d * 2^(2k), d = window_len + 1
    logic [TW-1:0] s_reg,  s_next;
    logic [TW-1:0] q_reg,  q_next;
    logic [TW-1:0] p_reg,  p_next;
    logic [TW-1:0] c2_reg, c2_next;
    logic [RW-1:0] bit_reg, bit_next;
    logic [RW-1:0] root_reg, root_next;
    logic [TW-1:0] trial;
    logic          fits;

    assign trial = q_reg + p_reg + c2_reg;
    assign fits  = (trial <= s_reg);

    always_comb
    begin
        s_next    = s_reg;
        q_next    = q_reg;
        p_next    = p_reg;
        c2_next   = c2_reg;
        bit_next  = bit_reg;
        root_next = root_reg;
        if (start)
        begin
            s_next    = TW'(value);
            q_next    = '0;
            p_next    = '0;
            c2_next   = C2_INIT;
            bit_next  = {1'b1, {(RW - 1){1'b0}}};
            root_next = '0;
        end
        else if (|bit_reg)
        begin
            if (fits)
            begin
                q_next    = trial;
                p_next    = (p_reg >> 1) + c2_reg;
                root_next = root_reg | bit_reg;
            end
            else
            begin
                p_next = p_reg >> 1;
            end
            c2_next  = c2_reg >> 2;
            bit_next = bit_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        q_reg    <= q_next;
        p_reg    <= p_next;
        c2_reg   <= c2_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign stat.busy = |bit_reg;
    assign stat.done = bit_reg[0];

endmodule

### rtl/rms_audio_compressor_unit.sv
// channel   direction  handshake              payload
// ------------------------------------------------------------------------------
// in        input      in_valid / in_ready    sample_in (signed q1.15)
// out       output     out_valid / out_ready  sample_out (signed q1.15), envelope (q1.15)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one input transaction is taken in the idle state; its work is the delay line read, the five
// passes through the shared multiplier and the bit-serial root loop, and no new sample is
// taken until the sequencer is back in idle
// after reset the delay line reads as zero until it has wrapped once (no clearing pass)
// a result waits in the output register while the next sample is taken; the sequencer
// only stalls at its last step when that register is still full
// cfg_ready is always high
module rms_audio_compressor_unit #(
    parameter int WINDOW_LEN = rac_pkg::WINDOW_LEN_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [rac_pkg::DATA_W-1:0]    sample_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rac_pkg::DATA_W-1:0]    sample_out,
    output logic [rac_pkg::DATA_W-1:0]           envelope,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rac_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rac_pkg::DATA_W-1:0]           cfg_data
);

    localparam int SUM_W = rac_pkg::sum_width(WINDOW_LEN);
    localparam int PTR_W = $clog2(WINDOW_LEN);
    localparam int DW    = rac_pkg::DATA_W;
    localparam int RW    = rac_pkg::ROOT_W;

    // sequencer, one hot
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_RD    = 11'b000_0000_0010,
        ST_SQO   = 11'b000_0000_0100,
        ST_SQX   = 11'b000_0000_1000,
        ST_ROOT  = 11'b000_0001_0000,
        ST_ENV   = 11'b000_0010_0000,
        ST_ENVW  = 11'b000_0100_0000,
        ST_GAIN  = 11'b000_1000_0000,
        ST_GAINW = 11'b001_0000_0000,
        ST_OUTM  = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [DW-1:0] thr_reg;
    logic [DW-1:0] slope_reg;
    logic [DW-1:0] atk_reg;
    logic [DW-1:0] rel_reg;

    // datapath state
    logic [PTR_W-1:0]                          ptr_reg, ptr_next;
    logic                                      filled_reg, filled_next;
    logic [SUM_W-1:0]                          sum_reg, sum_next;
    logic [DW-1:0]                             env_reg, env_next;
    logic signed [DW-1:0]                      x_reg, x_next;
    logic signed [DW-1:0]                      old_reg, old_next;
    logic signed [rac_pkg::MUL_B_W-1:0]        gain_reg, gain_next;

    // output register
    logic                                      out_valid_reg, out_valid_next;
    logic signed [DW-1:0]                      sample_out_reg, sample_out_next;
    logic [DW-1:0]                             env_out_reg, env_out_next;

    // memory and shared units
    logic                                      ram_we;
    logic [DW-1:0]                             ram_rdata;
    logic signed [DW-1:0]                      old_w;
    logic signed [rac_pkg::MUL_A_W-1:0]        mul_a;
    logic signed [rac_pkg::MUL_B_W-1:0]        mul_b;
    logic signed [rac_pkg::MUL_P_W-1:0]        mul_p;
    logic                                      root_start;
    logic [RW-1:0]                             root;
    rac_pkg::root_stat_t                       root_stat;

    // derived values
    logic [SUM_W-1:0]                          sq_w;
    logic [DW-1:0]                             coef;
    logic signed [rac_pkg::MUL_A_W-1:0]        env_diff;
    logic [rac_pkg::MUL_P_W-1:0]               env_acc;
    logic [DW-1:0]                             env_upd;
    logic [DW-1:0]                             excess;
    logic signed [rac_pkg::MUL_P_W-1:0]        y_round;
    logic signed [rac_pkg::MUL_P_W-1:0]        y_sh;
    logic signed [DW-1:0]                      y_sat;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign envelope   = env_out_reg;

    // delay line: read and write share the pointer, read data is registered and arrives in the next cycle
    rac_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW_LEN)
    ) u_delay (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (x_reg),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // entries not yet written since reset read as zero
    assign old_w = filled_reg ? $signed(ram_rdata) : '0;

    rac_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // rms = floor(sqrt(sum / (window_len + 1))) with the divide folded in
    rac_root #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (sum_next),
        .root  (root),
        .stat  (root_stat)
    );

    // squares are always nonnegative and below 2^31
    assign sq_w = mul_p[SUM_W-1:0];

    // attack when the rms rises above the envelope
    assign coef     = ({1'b0, root} > env_reg) ? atk_reg : rel_reg;
    assign env_diff = $signed({1'b0, env_reg}) - $signed({2'b00, root});

    // env = rms * 2^16 + c * (env - rms) + 2^15, then >> 16
    assign env_acc = rac_pkg::MUL_P_W'({root, 16'h0000}) + mul_p + rac_pkg::ENV_ROUND;
    assign env_upd = env_acc[31] ? rac_pkg::ENV_MAX : env_acc[31:16];

    // excess over the knee, zero at or below it
    assign excess = (env_reg > thr_reg) ? (env_reg - thr_reg) : '0;

    // round half up, floor shift, saturate
    assign y_round = mul_p + rac_pkg::OUT_ROUND;
    assign y_sh    = y_round >>> rac_pkg::GAIN_FRAC;

    always_comb
    begin
        if (y_sh > rac_pkg::SAMPLE_MAX)
        begin
            y_sat = rac_pkg::SAMPLE_MAX[DW-1:0];
        end
        else if (y_sh < rac_pkg::SAMPLE_MIN)
        begin
            y_sat = rac_pkg::SAMPLE_MIN[DW-1:0];
        end
        else
        begin
            y_sat = y_sh[DW-1:0];
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RD:
            begin
                mul_a = rac_pkg::MUL_A_W'(old_w);
                mul_b = rac_pkg::MUL_B_W'(old_w);
            end
            ST_SQO:
            begin
                mul_a = rac_pkg::MUL_A_W'(x_reg);
                mul_b = rac_pkg::MUL_B_W'(x_reg);
            end
            ST_ENV:
            begin
                mul_a = env_diff;
                mul_b = rac_pkg::MUL_B_W'(coef);
            end
            ST_GAIN:
            begin
                mul_a = rac_pkg::MUL_A_W'(excess);
                mul_b = rac_pkg::MUL_B_W'(slope_reg);
            end
            // held through the output stall so the product stays put
            ST_OUTM, ST_DONE:
            begin
                mul_a = rac_pkg::MUL_A_W'(old_reg);
                mul_b = gain_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        old_next        = old_reg;
        sum_next        = sum_reg;
        env_next        = env_reg;
        gain_next       = gain_reg;
        ptr_next        = ptr_reg;
        filled_next     = filled_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        sample_out_next = sample_out_reg;
        env_out_next    = env_out_reg;
        ram_we          = 1'b0;
        root_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = sample_in;
                    state_next = ST_RD;
                end
            end
            // oldest sample leaves, new one takes its slot
            ST_RD:
            begin
                old_next = old_w;
                ram_we   = 1'b1;
                if (ptr_reg == PTR_W'(WINDOW_LEN - 1))
                begin
                    ptr_next    = '0;
                    filled_next = 1'b1;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                state_next = ST_SQO;
            end
            // remove the old square first so the sum never overflows
            ST_SQO:
            begin
                sum_next   = sum_reg - sq_w;
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                sum_next   = sum_reg + sq_w;
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_stat.done)
                begin
                    state_next = ST_ENV;
                end
            end
            ST_ENV:
            begin
                state_next = ST_ENVW;
            end
            ST_ENVW:
            begin
                env_next   = env_upd;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                state_next = ST_GAINW;
            end
            ST_GAINW:
            begin
                gain_next  = rac_pkg::GAIN_ONE - $signed(mul_p[rac_pkg::MUL_B_W-1:0]);
                state_next = ST_OUTM;
            end
            ST_OUTM:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = y_sat;
                    env_out_next    = env_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            filled_reg    <= 1'b0;
            sum_reg       <= '0;
            env_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            filled_reg    <= filled_next;
            sum_reg       <= sum_next;
            env_reg       <= env_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        old_reg        <= old_next;
        gain_reg       <= gain_next;
        sample_out_reg <= sample_out_next;
        env_out_reg    <= env_out_next;
    end

    // configuration writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= rac_pkg::THRESHOLD_RST;
            slope_reg <= rac_pkg::SLOPE_RST;
            atk_reg   <= rac_pkg::ATTACK_RST;
            rel_reg   <= rac_pkg::RELEASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rac_pkg::CFG_THRESHOLD: thr_reg   <= cfg_data;
                rac_pkg::CFG_SLOPE:     slope_reg <= cfg_data;
                rac_pkg::CFG_ATTACK:    atk_reg   <= cfg_data;
                rac_pkg::CFG_RELEASE:   rel_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

### rtl/rac_checker.sv
module rac_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic signed [rac_pkg::DATA_W-1:0]    sample_in,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [rac_pkg::DATA_W-1:0]    sample_out,
    input logic [rac_pkg::DATA_W-1:0]           envelope,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [rac_pkg::CFG_IDX_W-1:0]        cfg_index,
    input logic [rac_pkg::DATA_W-1:0]           cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(envelope))
        else $error("result changed while stalled");

    // block is busy right after taking a sample
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an input transaction");

    // a new result only shows up at the end of a busy stretch
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

    // envelope never reaches full scale
    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !envelope[rac_pkg::DATA_W-1])
        else $error("envelope out of range");

endmodule

bind rms_audio_compressor_unit rac_checker u_rac_checker (.*);

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rac_pkg::*;

    // window length of the instance, kept as the default of the block
    localparam int WIN = WINDOW_LEN_DEF;

    // run shape
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 60;       // quiet cycles after the last result
    localparam int LIMIT_NS     = 2000000;  // several times the slowest legal run

    // register indexes past the four real registers, written to check they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;

    // segment shapes of the random audio stream
    typedef enum int {
        SEG_NOISE,
        SEG_LOUD,
        SEG_QUIET,
        SEG_SILENCE,
        SEG_SQUARE,
        SEG_BURST
    } seg_kind_t;

    // one compressed output transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] smp;
        logic [DATA_W-1:0]        env;
    } comp_out_t;

    // one row of the directed table; a set flag means the field value is typed in
    typedef struct packed {
        logic signed [DATA_W-1:0] smp;
        logic                     fix_out;
        logic signed [DATA_W-1:0] out_v;
        logic                     fix_env;
        logic [DATA_W-1:0]        env_v;
    } dir_row_t;

    localparam int DIR_ROWS = 16;

    // right after reset the delay line is clear, so every directed output sample is zero;
    // the envelope is plainly zero only while the window has seen nothing but silence
    dir_row_t dir_table [DIR_ROWS] = '{
        '{16'sh0000, 1'b1, 16'sh0000, 1'b1, 16'h0000},
        '{16'sh0000, 1'b1, 16'sh0000, 1'b1, 16'h0000},
        '{16'sh0000, 1'b1, 16'sh0000, 1'b1, 16'h0000},
        '{16'sh7fff, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'sh8000, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'sh8000, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'sh7fff, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'shffff, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'sh0001, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'sh5555, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'shaaaa, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'sh4000, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'shc000, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'sh0000, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'sh8001, 1'b1, 16'sh0000, 1'b0, 16'h0000},
        '{16'sh7ffe, 1'b1, 16'sh0000, 1'b0, 16'h0000}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] sample_in = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] sample_out;
    logic [DATA_W-1:0]        envelope;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;

    // predictor state: its own copy of the registers and the detector
    logic [DATA_W-1:0]        knee_thr = 16'd32768;
    logic [DATA_W-1:0]        knee_slope = 16'd0;
    logic [DATA_W-1:0]        attack_c = 16'd24109;
    logic [DATA_W-1:0]        release_c = 16'd24109;
    logic signed [DATA_W-1:0] hist [WIN];
    int unsigned              hist_ptr = 0;
    longint unsigned          energy = 0;
    longint unsigned          env_level = 0;

    // compressed samples owed by the block, oldest first
    comp_out_t owed_out [$];

    int err_count = 0;
    int taken_cnt = 0;
    int seen_cnt  = 0;

    // run controls shared between the two sides
    logic calm = 1'b0;          // final stretch: no idling anywhere
    logic steady = 1'b0;        // sender keeps offering with no gaps
    logic hold_pending = 1'b0;  // asks the receiver for its long hold-off

    rms_audio_compressor_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .envelope   (envelope),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #LIMIT_NS;
        $display("testbench: errors");
        $finish;
    end

    task automatic flag_error(input string what);
        $display("mismatch: %s", what);
        err_count++;
    endtask

    // floor of the square root, one result bit at a time from the top
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // one step of the compressor: window energy, rms, envelope follower, knee gain
    function automatic comp_out_t compress_step(input logic signed [DATA_W-1:0] x);
        logic signed [DATA_W-1:0] leaving;
        longint unsigned          rms;
        longint unsigned          coef;
        longint unsigned          acc;
        longint                   gain;
        longint                   prod;
        longint                   y;
        comp_out_t                res;

        // delay line: the oldest sample leaves, the new one takes its slot
        leaving = hist[hist_ptr];
        hist[hist_ptr] = x;
        hist_ptr = (hist_ptr == WIN - 1) ? 0 : hist_ptr + 1;

        // exact running sum of squares over the window
        energy = energy + longint'(x) * longint'(x);
        energy = energy - longint'(leaving) * longint'(leaving);

        // rms over window+1, mean truncated and root floored
        rms = floor_root(energy / longint'(WIN + 1));
        if (rms > 32767)
            rms = 32767;

        // attack only when the rms is strictly above the envelope
        coef = (rms > env_level) ? longint'(attack_c) : longint'(release_c);
        acc = (65536 - coef) * rms + coef * env_level + 32768;
        env_level = acc >> 16;
        if (env_level > 32767)
            env_level = 32767;

        // hard knee: q5.27 gain, may go negative for steep slopes
        gain = longint'(1) << 27;
        if (env_level > longint'(knee_thr))
            gain = gain - longint'(env_level - longint'(knee_thr)) * longint'(knee_slope);

        // round half up with a floor shift, then saturate
        prod = longint'(leaving) * gain;
        y = (prod + (longint'(1) << 26)) >>> 27;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;

        res.smp = DATA_W'(y);
        res.env = DATA_W'(env_level);
        return res;
    endfunction

    // offer one sample and wait for its transaction; the owed result is booked on accept
    task automatic send_sample(input logic signed [DATA_W-1:0] s,
                               input logic fix_out = 1'b0,
                               input logic signed [DATA_W-1:0] out_v = '0,
                               input logic fix_env = 1'b0,
                               input logic [DATA_W-1:0] env_v = '0);
        comp_out_t due;
        @(negedge clk);
        in_valid  <= 1'b1;
        sample_in <= s;
        do
            @(posedge clk);
        while (!in_ready);
        due = compress_step(s);
        if (fix_out)
            due.smp = out_v;
        if (fix_env)
            due.env = env_v;
        owed_out.push_back(due);
        taken_cnt++;
    endtask

    // sender gap of a given number of cycles
    task automatic idle_input(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // drop valid after the last sample of a stretch and wait for every owed result
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_out.size() != 0)
            @(posedge clk);
    endtask

    // one register write transaction; valid is left high for a following write
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (cfg_idx_t'(idx))
            CFG_THRESHOLD: knee_thr = val;
            CFG_SLOPE:     knee_slope = val;
            CFG_ATTACK:    attack_c = val;
            CFG_RELEASE:   release_c = val;
            default: ;
        endcase
    endtask

    // full set of knee and follower settings, optionally with a stray index write
    task automatic set_knee(input logic [DATA_W-1:0] thr, input logic [DATA_W-1:0] slp,
                            input logic [DATA_W-1:0] atk, input logic [DATA_W-1:0] rel,
                            input logic stray);
        reg_write(CFG_THRESHOLD, thr);
        reg_write(CFG_SLOPE, slp);
        if (stray)
            reg_write(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 3)), DATA_W'($urandom));
        reg_write(CFG_ATTACK, atk);
        reg_write(CFG_RELEASE, rel);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random audio: segments of noise, loud passages, quiet, silence, square tones and sparse bursts
    task automatic play_audio(input int n_items);
        int                       left;
        int                       seg_len;
        int                       amp;
        int                       half;
        seg_kind_t                kind;
        logic                     gappy;
        logic signed [DATA_W-1:0] s;
        left = n_items;
        while (left > 0)
        begin
            kind    = seg_kind_t'($urandom_range(0, 5));
            seg_len = $urandom_range(8, 64);
            if (seg_len > left)
                seg_len = left;
            amp   = $urandom_range(1, 32767);
            half  = $urandom_range(1, 24);
            gappy = !calm && !steady && ($urandom_range(0, 2) != 0);
            for (int k = 0; k < seg_len; k++)
            begin
                case (kind)
                    SEG_NOISE:   s = DATA_W'($urandom);
                    SEG_LOUD:    s = $urandom_range(0, 1) ?
                                     16'sh7fff - DATA_W'($urandom_range(0, 2047)) :
                                     16'sh8000 + DATA_W'($urandom_range(0, 2047));
                    SEG_QUIET:   s = DATA_W'($urandom_range(0, 1023)) - 16'sd512;
                    SEG_SILENCE: s = '0;
                    SEG_SQUARE:  s = ((k / half) % 2 == 1) ? -DATA_W'(amp) : DATA_W'(amp);
                    default:     s = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom) : '0;
                endcase
                if (gappy && $urandom_range(0, 3) == 0)
                    idle_input($urandom_range(1, 12));
                send_sample(s);
            end
            left -= seg_len;
        end
    endtask

    // receiver: random stall bursts in changing moods, one long hold-off on request
    initial
    begin : out_side
        int stall_left;
        int mood;
        int mood_left;
        stall_left = 0;
        mood = 0;
        mood_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            // mood 0: always ready, 1: light stalls, 2: heavy stalls
            if (mood_left == 0)
            begin
                mood = $urandom_range(0, 2);
                mood_left = $urandom_range(20, 120);
            end
            mood_left--;
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!calm && mood != 0 && $urandom_range(0, (mood == 1) ? 15 : 3) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(1, 12) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // result check: every output transaction against the oldest owed result
    always @(posedge clk)
    begin : out_check
        comp_out_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_out.size() == 0)
                flag_error($sformatf("result %0d arrived with nothing owed", seen_cnt));
            else
            begin
                due = owed_out.pop_front();
                if (sample_out !== due.smp)
                    flag_error($sformatf("result %0d sample_out %0d, wanted %0d",
                                         seen_cnt, sample_out, due.smp));
                if (envelope !== due.env)
                    flag_error($sformatf("result %0d envelope %0d, wanted %0d",
                                         seen_cnt, envelope, due.env));
            end
            seen_cnt++;
        end
    end

    // main sequence
    initial
    begin : main_seq
        for (int i = 0; i < WIN; i++)
            hist[i] = '0;

        // reset held at start, released on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows on reset settings: silence, extremes, alternating bit patterns
        for (int r = 0; r < DIR_ROWS; r++)
            send_sample(dir_table[r].smp, dir_table[r].fix_out, dir_table[r].out_v,
                        dir_table[r].fix_env, dir_table[r].env_v);

        // reset settings keep the knee at full scale: samples pass through once the window fills;
        // midway the receiver holds off while the sender keeps pushing, so the block backs up
        play_audio(150);
        hold_pending = 1'b1;
        steady = 1'b1;
        play_audio(40);
        steady = 1'b0;
        play_audio(110);
        settle();

        // zero threshold, steepest slope, instant envelope: gain goes negative and saturates
        set_knee(16'd0, 16'hffff, 16'd0, 16'd0, 1'b1);
        play_audio(100);
        settle();

        // knee just below full scale with slowest follower: the envelope barely moves
        set_knee(16'd32767, 16'hffff, 16'hffff, 16'hffff, 1'b0);
        play_audio(100);
        settle();

        // unity slope at half scale, fast attack and slow release
        set_knee(16'd16384, 16'd4096, 16'd8000, 16'd64000, 1'b1);
        play_audio(100);
        settle();

        // random settings: threshold up to 32768, the other registers over their whole ranges
        repeat (3)
        begin
            set_knee(DATA_W'($urandom_range(0, 32768)), DATA_W'($urandom),
                     DATA_W'($urandom), DATA_W'($urandom), $urandom_range(0, 1));
            play_audio(70);
            settle();
        end

        // last stretch with no idling on either side
        calm = 1'b1;
        set_knee(16'd8192, 16'h2000, 16'd60000, 16'd65000, 1'b0);
        play_audio(100);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
